// ===== hw/rtl/mfr_pkg.sv =====
// Package for the mesh frame relay rewriter.
// Holds frame offsets, status codes, the result record and the CRC-16 byte update.
// No dependencies.
package mfr_pkg;

  // Header positions within a frame
  localparam logic [7:0] POS_SRC     = 8'd1;
  localparam logic [7:0] POS_SEQ_LO  = 8'd5;
  localparam logic [7:0] POS_SEQ_HI  = 8'd6;
  localparam logic [7:0] POS_TTL     = 8'd7;
  localparam logic [7:0] POS_HOPCNT  = 8'd8;
  localparam logic [7:0] POS_FLAGBYTE = 8'd9;

  localparam int unsigned MIN_FRAME_LEN = 12;
  localparam int unsigned MAX_FRAME_LEN = 255;

  localparam logic [7:0]  MASK_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Result queue
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned PTR_W     = $clog2(RES_DEPTH);
  localparam int unsigned LVL_W     = PTR_W + 1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_CRC_ERR   = 3'd2,
    ST_TTL_EXP   = 3'd3,
    ST_OVERSIZE  = 3'd4
  } status_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  status;
    logic [7:0]  src_id;
    logic [15:0] msg_id;
    logic        no_relay;
    logic [7:0]  ttl_after;
    logic [7:0]  hops_after;
  } res_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Frame byte result: everything but the byte is zero
  function automatic res_t byte_res(input logic [7:0] b);
    res_t r;
    r      = '0;
    r.data = b;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mfr_cfg_if.sv =====
// Configuration write channel of the relay rewriter.
// Carries the relay flag mask; no dependencies.
interface mfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mfr_in_if.sv =====
// Input byte channel of the relay rewriter.
// Carries one received frame byte and its end marker; no dependencies.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/mfr_out_if.sv =====
// Result channel of the relay rewriter.
// Carries emitted frame bytes and the end-of-frame verdict; no dependencies.
interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [2:0]  status;
  logic [7:0]  src_id;
  logic [15:0] msg_id;
  logic        no_relay;
  logic [7:0]  ttl_after;
  logic [7:0]  hops_after;

  modport source (output valid, output out_kind, output out_byte, output out_last,
                  output status, output src_id, output msg_id, output no_relay,
                  output ttl_after, output hops_after, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_last,
                  input status, input src_id, input msg_id, input no_relay,
                  input ttl_after, input hops_after, output ready);
endinterface

// ===== hw/rtl/mesh_frame_relay_rewriter.sv =====
// Mesh frame relay rewriter, top level.
// Depends on mfr_pkg and the interfaces mfr_cfg_if, mfr_in_if, mfr_out_if.
//
//   channel  | dir | transfer                         | payload
//   ---------+-----+----------------------------------+-----------------------------
//   cfg_i    | in  | one relay flag mask write        | data[7:0]
//   in_i     | in  | one raw frame byte               | in_byte, in_last
//   out_o    | out | one emitted byte or the verdict  | out_kind .. hops_after
//
// Cycles: one byte is taken per cycle while in_i.ready is high. Each byte is worked
// out in the cycle of its transfer and its results (zero to four) go into an 8-entry
// result queue that drains one result per cycle while out_o.ready is high; in_i.ready
// drops while the queue holds more than four results. A frame gives one result more
// than it has bytes (the verdict), so with out_o always ready in_i still stalls at times.
// Reset: asynchronous, active low; in_i.ready is high out of reset, so a byte can
// be taken right after release, with mask 0x01 and an empty frame.
// cfg_i is always ready. Stalls on out_o fill the queue and then back-pressure in_i.
module mesh_frame_relay_rewriter
  import mfr_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_FRAME_LEN
)
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mfr_cfg_if.sink    cfg_i,
  mfr_in_if.sink     in_i,
  mfr_out_if.source  out_o
);

  // Frame state
  logic [7:0]       mask_q;
  logic [1:0][7:0]  hold_q, hold_d;
  logic [1:0]       fill_q, fill_d;
  logic [7:0]       count_q, count_d;
  logic [15:0]      rx_crc_q, rx_crc_d;
  logic [15:0]      em_crc_q, em_crc_d;
  logic             ttl_zero_q, ttl_zero_d;
  logic [7:0]       src_q, src_d;
  logic [15:0]      seq_q, seq_d;
  logic [7:0]       flags_q, flags_d;
  logic [7:0]       ttl_q, ttl_d;
  logic [7:0]       hops_q, hops_d;

  // Result queue
  res_t             fifo_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] level_q, level_d;

  logic             in_xfer, out_xfer;
  res_t             res [MAX_RES];
  logic [2:0]       n_push;

  // Per-byte scratch
  logic             depart;
  logic [7:0]       pos;
  logic [7:0]       dep_out;
  logic             short_frame;
  status_e          status;
  logic [2:0]       slot;
  res_t             verdict;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;
  assign cfg_i.ready = 1'b1;

  // Keep room for the worst case of one byte: a departing byte, two flushed bytes
  // and the verdict.
  assign in_i.ready = level_q <= LVL_W'(RES_DEPTH - MAX_RES);

  always_comb begin
    hold_d     = hold_q;
    fill_d     = fill_q;
    rx_crc_d   = rx_crc_q;
    em_crc_d   = em_crc_q;
    ttl_zero_d = ttl_zero_q;
    src_d      = src_q;
    seq_d      = seq_q;
    flags_d    = flags_q;
    ttl_d      = ttl_q;
    hops_d     = hops_q;
    count_d    = (count_q != 8'hFF) ? count_q + 8'd1 : count_q;
    for (int k = 0; k < MAX_RES; k++) begin
      res[k] = '0;
    end
    slot    = 3'd0;
    verdict = '0;
    status  = ST_OK;

    // Capture header fields as they arrive
    if (count_q == POS_SRC)      src_d        = in_i.in_byte;
    if (count_q == POS_SEQ_LO)   seq_d[7:0]   = in_i.in_byte;
    if (count_q == POS_SEQ_HI)   seq_d[15:8]  = in_i.in_byte;
    if (count_q == POS_FLAGBYTE) flags_d      = in_i.in_byte;

    // Oldest held byte leaves once two are held; rewrite TTL and hops on the way out
    depart  = fill_q[1];
    pos     = count_q - 8'd2;
    dep_out = hold_q[0];
    if (depart) begin
      rx_crc_d = crc16_byte(rx_crc_q, hold_q[0]);
      if (pos == POS_TTL) begin
        if (hold_q[0] == 8'h00) begin
          ttl_zero_d = 1'b1;
        end else begin
          dep_out = hold_q[0] - 8'd1;
        end
        ttl_d = dep_out;
      end else if (pos == POS_HOPCNT) begin
        if (!ttl_zero_q) dep_out = hold_q[0] + 8'd1;
        hops_d = dep_out;
      end
      em_crc_d  = crc16_byte(em_crc_q, dep_out);
      hold_d[0] = hold_q[1];
      hold_d[1] = in_i.in_byte;
      res[slot[1:0]] = byte_res(dep_out);
      slot = slot + 3'd1;
    end else begin
      hold_d[fill_q[0]] = in_i.in_byte;
      fill_d = fill_q + 2'd1;
    end

    short_frame = count_q < 8'(MIN_FRAME_LEN - 1);
    priority if (short_frame)                               status = ST_SHORT;
    else if (count_q >= 8'(MAX_LEN))                        status = ST_OVERSIZE;
    else if (rx_crc_d != {hold_d[1], hold_d[0]})            status = ST_CRC_ERR;
    else if (ttl_zero_d)                                    status = ST_TTL_EXP;
    else                                                    status = ST_OK;

    if (in_i.in_last) begin
      // Flush the trailing pair: fresh CRC on a good frame, original bytes otherwise
      if (status == ST_OK) begin
        res[slot[1:0]] = byte_res(em_crc_d[7:0]);
        slot = slot + 3'd1;
        res[slot[1:0]] = byte_res(em_crc_d[15:8]);
        slot = slot + 3'd1;
      end else begin
        if (fill_d != 2'd0) begin
          res[slot[1:0]] = byte_res(hold_d[0]);
          slot = slot + 3'd1;
        end
        if (fill_d[1]) begin
          res[slot[1:0]] = byte_res(hold_d[1]);
          slot = slot + 3'd1;
        end
      end

      verdict.kind   = 1'b1;
      verdict.last   = 1'b1;
      verdict.status = status;
      if (short_frame) begin
        verdict.no_relay = 1'b1;
      end else begin
        verdict.src_id     = src_d;
        verdict.msg_id     = seq_d;
        verdict.no_relay   = (flags_d & mask_q) != 8'h00;
        verdict.ttl_after  = ttl_d;
        verdict.hops_after = hops_d;
      end
      res[slot[1:0]] = verdict;
      slot = slot + 3'd1;

      // Drop all frame state for the next frame
      hold_d     = '0;
      fill_d     = 2'd0;
      count_d    = 8'd0;
      rx_crc_d   = CRC_INIT;
      em_crc_d   = CRC_INIT;
      ttl_zero_d = 1'b0;
      src_d      = 8'd0;
      seq_d      = 16'd0;
      flags_d    = 8'd0;
      ttl_d      = 8'd0;
      hops_d     = 8'd0;
    end
    n_push = slot;
  end

  always_comb begin
    level_d = level_q;
    if (in_xfer) level_d = level_d + LVL_W'(n_push);
    if (out_xfer) level_d = level_d - LVL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= MASK_RESET;
      hold_q     <= '0;
      fill_q     <= 2'd0;
      count_q    <= 8'd0;
      rx_crc_q   <= CRC_INIT;
      em_crc_q   <= CRC_INIT;
      ttl_zero_q <= 1'b0;
      src_q      <= 8'd0;
      seq_q      <= 16'd0;
      flags_q    <= 8'd0;
      ttl_q      <= 8'd0;
      hops_q     <= 8'd0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      level_q    <= '0;
    end else begin
      if (cfg_i.valid) mask_q <= cfg_i.data;
      if (in_xfer) begin
        hold_q     <= hold_d;
        fill_q     <= fill_d;
        count_q    <= count_d;
        rx_crc_q   <= rx_crc_d;
        em_crc_q   <= em_crc_d;
        ttl_zero_q <= ttl_zero_d;
        src_q      <= src_d;
        seq_q      <= seq_d;
        flags_q    <= flags_d;
        ttl_q      <= ttl_d;
        hops_q     <= hops_d;
        wr_ptr_q   <= wr_ptr_q + PTR_W'(n_push);
      end
      if (out_xfer) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      level_q <= level_d;
    end
  end

  // Queue storage: payload only, no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (in_xfer && (3'(k) < n_push)) begin
        fifo_q[wr_ptr_q + PTR_W'(k)] <= res[k];
      end
    end
  end

  // Present the head of the queue
  assign out_o.valid      = level_q != '0;
  assign out_o.out_kind   = fifo_q[rd_ptr_q].kind;
  assign out_o.out_byte   = fifo_q[rd_ptr_q].data;
  assign out_o.out_last   = fifo_q[rd_ptr_q].last;
  assign out_o.status     = fifo_q[rd_ptr_q].status;
  assign out_o.src_id     = fifo_q[rd_ptr_q].src_id;
  assign out_o.msg_id     = fifo_q[rd_ptr_q].msg_id;
  assign out_o.no_relay   = fifo_q[rd_ptr_q].no_relay;
  assign out_o.ttl_after  = fifo_q[rd_ptr_q].ttl_after;
  assign out_o.hops_after = fifo_q[rd_ptr_q].hops_after;

endmodule

// ===== bench/mesh_frame_relay_rewriter_test.sv =====
// Self-checking bench for the mesh frame relay rewriter.
// Depends on mfr_pkg, the interfaces mfr_cfg_if, mfr_in_if, mfr_out_if and the top level.
`timescale 1ns / 1ps

module mesh_frame_relay_rewriter_test;
  import mfr_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  localparam logic [15:0] CCITT_POLY = 16'h1021;
  localparam logic [15:0] CCITT_SEED = 16'hFFFF;
  // No transfer on any channel for this many cycles means the block hung
  localparam int unsigned STUCK_LIMIT = 2000;
  // Cycles to let the block settle once every result is in
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  mfr_cfg_if cfg_if ();
  mfr_in_if  in_if ();
  mfr_out_if out_if ();

  mesh_frame_relay_rewriter #(
    .MAX_LEN (MAX_FRAME_LEN)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Bench-wide knobs and bookkeeping
  bit          in_gaps;
  bit          out_gaps;
  int unsigned long_hold;
  int unsigned bytes_sent;
  int unsigned mismatches;
  int unsigned stuck_cycles;

  // Results still owed by the block, oldest first
  res_t due_results [$];

  // Shadow of the block: mask register and per-frame state
  logic [7:0]  relay_mask;
  logic [7:0]  delay_line [2];
  int unsigned delay_fill;
  logic [7:0]  frame_pos;
  logic [15:0] rx_crc;
  logic [15:0] tx_crc;
  logic        ttl_hit_zero;
  logic [7:0]  src_seen;
  logic [15:0] seq_seen;
  logic [7:0]  flags_seen;
  logic [7:0]  ttl_out;
  logic [7:0]  hops_out;

  // CRC-16/CCITT-FALSE, one message bit at a time, MSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    delay_line[0] = '0;
    delay_line[1] = '0;
    delay_fill    = 0;
    frame_pos     = '0;
    rx_crc        = CCITT_SEED;
    tx_crc        = CCITT_SEED;
    ttl_hit_zero  = 1'b0;
    src_seen      = '0;
    seq_seen      = '0;
    flags_seen    = '0;
    ttl_out       = '0;
    hops_out      = '0;
  endfunction

  function automatic void owe_byte(input logic [7:0] b);
    res_t r;
    r      = '0;
    r.data = b;
    due_results.push_back(r);
  endfunction

  // Byte leaving the two-deep delay line at frame offset at: run both CRCs,
  // rewrite TTL and hop count on the way out.
  function automatic logic [7:0] depart_byte(input logic [7:0] at, input logic [7:0] v);
    logic [7:0] o;
    rx_crc = crc_step(rx_crc, v);
    o      = v;
    if (at == POS_TTL) begin
      if (v == 8'h00) ttl_hit_zero = 1'b1;
      else o = v - 8'd1;
      ttl_out = o;
    end else if (at == POS_HOPCNT) begin
      if (!ttl_hit_zero) o = v + 8'd1;
      hops_out = o;
    end
    tx_crc = crc_step(tx_crc, o);
    return o;
  endfunction

  // Work out every result one accepted input byte causes
  function automatic void relay_step(input logic [7:0] b, input logic last);
    logic [7:0] at;
    status_e    verdict;
    res_t       r;
    bit         short_frame;
    at = frame_pos;
    if (at == POS_SRC)      src_seen        = b;
    if (at == POS_SEQ_LO)   seq_seen[7:0]   = b;
    if (at == POS_SEQ_HI)   seq_seen[15:8]  = b;
    if (at == POS_FLAGBYTE) flags_seen      = b;
    if (delay_fill >= 2) begin
      owe_byte(depart_byte(at - 8'd2, delay_line[0]));
      delay_line[0] = delay_line[1];
      delay_line[1] = b;
    end else begin
      delay_line[delay_fill] = b;
      delay_fill++;
    end
    if (frame_pos != 8'hFF) frame_pos++;
    if (!last) return;

    short_frame = (32'(at) + 1) < MIN_FRAME_LEN;
    if (short_frame) verdict = ST_SHORT;
    else if (32'(at) >= MAX_FRAME_LEN) verdict = ST_OVERSIZE;
    else if (rx_crc != {delay_line[1], delay_line[0]}) verdict = ST_CRC_ERR;
    else if (ttl_hit_zero) verdict = ST_TTL_EXP;
    else verdict = ST_OK;

    // Flush the held pair: fresh CRC on a good frame, the original bytes otherwise
    if (verdict == ST_OK) begin
      owe_byte(tx_crc[7:0]);
      owe_byte(tx_crc[15:8]);
    end else begin
      for (int i = 0; i < delay_fill; i++) owe_byte(delay_line[i]);
    end

    r        = '0;
    r.kind   = 1'b1;
    r.last   = 1'b1;
    r.status = verdict;
    if (short_frame) begin
      r.no_relay = 1'b1;
    end else begin
      r.src_id     = src_seen;
      r.msg_id     = seq_seen;
      r.no_relay   = (flags_seen & relay_mask) != 8'h00;
      r.ttl_after  = ttl_out;
      r.hops_after = hops_out;
    end
    due_results.push_back(r);
    clear_frame();
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result checker: compare each output transfer with the oldest owed result
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0b byte 0x%0h status %0d",
                 $time, out_if.out_kind, out_if.out_byte, out_if.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("out_kind",   want.kind,       out_if.out_kind);
        check_field("out_byte",   want.data,       out_if.out_byte);
        check_field("out_last",   want.last,       out_if.out_last);
        check_field("status",     want.status,     out_if.status);
        check_field("src_id",     want.src_id,     out_if.src_id);
        check_field("msg_id",     want.msg_id,     out_if.msg_id);
        check_field("no_relay",   want.no_relay,   out_if.no_relay);
        check_field("ttl_after",  want.ttl_after,  out_if.ttl_after);
        check_field("hops_after", want.hops_after, out_if.hops_after);
      end
    end
  end

  // Watchdog: end the run if no channel moves a transfer for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
        $display("mesh_frame_relay_rewriter_test: FAIL");
        $finish;
      end
    end
  end

  // Receiver: drop ready for a requested long hold, or in random bursts when
  // output gaps are on; otherwise accept every cycle.
  initial begin
    int unsigned burst;
    out_if.ready = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        out_if.ready <= 1'b0;
        long_hold--;
      end else if (burst > 0) begin
        out_if.ready <= 1'b0;
        burst--;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        burst = $urandom_range(0, 8);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one byte from a falling edge, hold it until the block takes it,
  // then predict. Return on the next falling edge with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do @(posedge clk_i); while (!in_if.ready);
    relay_step(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input octet_q_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Append the little-endian CRC of the body, optionally damaged, and send
  task automatic send_sealed(input octet_q_t body, input bit corrupt);
    logic [15:0] c;
    c = CCITT_SEED;
    foreach (body[i]) c = crc_step(c, body[i]);
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    send_bytes(body);
  endtask

  // Well-formed frame of len bytes with random header and payload
  task automatic send_frame(input int unsigned len, input bit ttl_zero, input bit corrupt);
    octet_q_t    body;
    logic [7:0]  v;
    int unsigned pick;
    for (int i = 0; i < len - 2; i++) begin
      v = 8'($urandom);
      if (i == POS_TTL) begin
        pick = $urandom_range(0, 5);
        if (ttl_zero) v = 8'h00;
        else if (pick == 0) v = 8'h01;
        else if (pick == 1) v = 8'hFF;
        else v = 8'($urandom_range(1, 255));
      end else if (i == POS_HOPCNT && $urandom_range(0, 7) == 0) begin
        v = 8'hFF;
      end
      body.push_back(v);
    end
    send_sealed(body, corrupt);
  endtask

  // Random bytes with the end marker on the last one only
  task automatic send_noise(input int unsigned len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
  endtask

  // Drop valid and wait until every owed result has come out, then settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mask(input logic [7:0] v);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    relay_mask = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Shortest good frame with extreme header values; the reset mask marks it
  // as not to be relayed, TTL drops to zero and hops wrap to zero.
  task automatic test_min_frame();
    octet_q_t body;
    body = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h01};
    send_sealed(body, 1'b0);
    wait_idle();
  endtask

  // One-byte and two-byte frames: only the held bytes come back, then a short verdict
  task automatic test_tiny_frames();
    octet_q_t q;
    q = '{8'hFF};
    send_bytes(q);
    q = '{8'h00, 8'hFF};
    send_bytes(q);
    wait_idle();
  endtask

  // TTL of zero: the frame passes unchanged with its original CRC
  task automatic test_ttl_expired();
    octet_q_t body;
    body = '{8'h5A, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'h00, 8'h7F, 8'hFE};
    send_sealed(body, 1'b0);
    wait_idle();
  endtask

  // Walk the mask through its extremes and a random value, then back to reset
  task automatic test_relay_mask();
    octet_q_t masks;
    masks = '{8'h00, 8'hFF, 8'h80};
    masks.push_back(8'($urandom));
    masks.push_back(MASK_RESET);
    foreach (masks[m]) begin
      write_mask(masks[m]);
      send_frame($urandom_range(12, 14), 1'b0, 1'b0);
    end
    wait_idle();
  endtask

  // Mostly good frames with random content, plus expired, damaged, short
  // and junk frames; gaps switch on and off per frame.
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = bytes_sent;
    while (bytes_sent - start < 40) begin
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      pick     = $urandom_range(0, 9);
      len      = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(12, 24);
      case (pick)
        6: begin
          send_frame(len, 1'b1, 1'b0);
        end
        7: begin
          send_frame(len, $urandom_range(0, 1), 1'b1);
        end
        8: begin
          send_noise($urandom_range(1, 11));
        end
        9: begin
          send_noise($urandom_range(1, 20));
        end
        default: begin
          send_frame(len, 1'b0, 1'b0);
        end
      endcase
      if ($urandom_range(0, 19) == 0) write_mask(8'($urandom));
    end
    wait_idle();
  endtask

  // Hold the output off for a long stretch while frames keep coming, so the
  // result queue fills and the block stalls its input.
  task automatic test_output_stall();
    in_gaps   = 1'b0;
    out_gaps  = 1'b0;
    long_hold = 300;
    repeat (2) send_frame(16, 1'b0, 1'b0);
    wait_idle();
  endtask

  // One byte past the largest legal frame, where the count saturates
  task automatic test_oversize();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    send_frame(MAX_FRAME_LEN + 1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Back-to-back frames at full rate, no idling on either side
  task automatic test_steady_stream();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (2) send_frame($urandom_range(12, 20), 1'b0, 1'b0);
    wait_idle();
  endtask

  initial begin
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    in_gaps       = 1'b0;
    out_gaps      = 1'b0;
    long_hold     = 0;
    bytes_sent    = 0;
    mismatches    = 0;
    stuck_cycles  = 0;
    relay_mask    = MASK_RESET;
    clear_frame();

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_min_frame();
    test_tiny_frames();
    test_ttl_expired();
    test_relay_mask();
    test_random_traffic();
    test_output_stall();
    test_oversize();
    test_steady_stream();
    wait_idle();

    if (mismatches == 0) begin
      $display("mesh_frame_relay_rewriter_test: PASS");
    end else begin
      $display("mesh_frame_relay_rewriter_test: FAIL");
    end
    $finish;
  end

endmodule
